FILE: rtl/surface_patch_neighbor_update_unit_macros.svh
// assertion macros for the surface patch neighbor update unit
`ifndef SURFACE_PATCH_NEIGHBOR_UPDATE_UNIT_MACROS_SVH
`define SURFACE_PATCH_NEIGHBOR_UPDATE_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define SPN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// property that holds at every clock outside reset
`define SPN_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`endif

FILE: rtl/spnu_pkg.sv
// shared types and constants of the surface patch neighbor update unit
`default_nettype none
package spnu_pkg;
  localparam int PATCH_LEN = 10;
  localparam int NUM_DIRS = 4;
  localparam int ACC_W = 48;
  localparam int WADDR_W = 9;
  localparam int IMAGE_DIM = 1024;
  localparam int COORD_W = $clog2(IMAGE_DIM);

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_CENTER = 2'd1,
    OP_NEIGHBOR = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam logic [1:0] MODE_THRESH = 2'd1;
  localparam logic [1:0] MODE_MASK = 2'd2;
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  // classified item passed from front to back
  typedef struct packed {
    logic               acc;
    logic               emit;
    logic [1:0]         dir;
    logic [3:0]         j;
    logic [31:0]        a;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } work_t;
endpackage
`default_nettype wire

FILE: rtl/spnu_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module spnu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 400
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/spnu_front.sv
// front end: weight and center loads, substitution decision, work queue
`default_nettype none
`include "surface_patch_neighbor_update_unit_macros.svh"
module spnu_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  subst_mode,
  input  wire logic [30:0] break_threshold,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [1:0]  direction,
  input  wire logic [3:0]  weight_row,
  input  wire logic [3:0]  coef_index,
  input  wire logic [31:0] value,
  input  wire logic [7:0]  label,
  input  wire logic [spnu_pkg::COORD_W-1:0] pixel_x,
  input  wire logic [spnu_pkg::COORD_W-1:0] pixel_y,
  input  wire logic        last,
  output logic             w_we,
  output logic [spnu_pkg::WADDR_W-1:0] w_waddr,
  output logic [31:0]      w_wdata,
  output logic             q_valid,
  input  wire logic        q_ready,
  output spnu_pkg::work_t  q_item
);
  logic [31:0] center [spnu_pkg::PATCH_LEN];
  logic [7:0]  center_label;
  logic [3:0]  replace_flags;
  spnu_pkg::work_t qmem [2];
  logic [1:0] count;
  logic wp, rp;
  logic acc, rep, use_rep, push, pop, in_range;
  logic [32:0] diff, adiff;
  spnu_pkg::work_t w;
  spnu_pkg::opcode_t op;

  assign op = spnu_pkg::opcode_t'(opcode);
  assign in_range = coef_index < 4'(spnu_pkg::PATCH_LEN);
  // a weight load waits until the back end has no queued or running reads
  assign in_ready = count != 2'd2
                    && !(op == spnu_pkg::OP_WEIGHT && (count != 2'd0 || !q_ready));
  assign push = in_valid && in_ready;
  assign q_valid = count != 2'd0;
  assign q_item = qmem[rp];
  assign pop = q_valid && q_ready;

  assign diff = {center[0][31], center[0]} - {value[31], value};
  assign adiff = diff[32] ? -diff : diff;

  always_comb begin
    rep = 1'b0;
    if (subst_mode == spnu_pkg::MODE_THRESH) rep = adiff > {2'b00, break_threshold};
    else if (subst_mode == spnu_pkg::MODE_MASK) rep = label != center_label;
  end

  assign use_rep = (coef_index == 4'd0) ? rep : replace_flags[direction];
  assign acc = (op == spnu_pkg::OP_NEIGHBOR) && in_range;

  always_comb begin
    w.acc = acc;
    w.emit = (op == spnu_pkg::OP_NEIGHBOR) && last;
    w.dir = direction;
    w.j = coef_index;
    w.a = use_rep ? center[coef_index[3:0] < 4'(spnu_pkg::PATCH_LEN) ? coef_index : 4'd0]
                  : value;
    w.px = pixel_x;
    w.py = pixel_y;
  end

  assign w_we = push && op == spnu_pkg::OP_WEIGHT && in_range
                && weight_row < 4'(spnu_pkg::PATCH_LEN);
  assign w_waddr = spnu_pkg::WADDR_W'(({7'd0, direction} * 9'(spnu_pkg::PATCH_LEN)
                   + {5'd0, weight_row}) * 9'(spnu_pkg::PATCH_LEN) + {5'd0, coef_index});
  assign w_wdata = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; wp <= 1'b0; rp <= 1'b0;
      center_label <= '0; replace_flags <= '0;
    end else begin
      if (push && op == spnu_pkg::OP_CENTER && in_range) begin
        center[coef_index] <= value;
        if (coef_index == 4'd0) center_label <= label;
      end
      if (push && acc && coef_index == 4'd0) replace_flags[direction] <= rep;
      if (push && (w.acc || w.emit)) begin
        qmem[wp] <= w; wp <= ~wp;
      end
      if (pop) rp <= ~rp;
      count <= count + 2'(push && (w.acc || w.emit)) - 2'(pop);
    end
  end

  `SPN_ASSERT_ALWAYS(a_count_max, clk, rst, count <= 2'd2, "queue overflow")
  `SPN_ASSERT_IMPL(a_empty_nopop, clk, rst, count == 2'd0, !pop, "pop from empty queue")
  `SPN_ASSERT_IMPL(a_wr_range, clk, rst, w_we, w_waddr < 9'd400, "weight address out of range")
endmodule
`default_nettype wire

FILE: rtl/spnu_back.sv
// back end: ten multiply-accumulate steps per in-range coefficient, ten results after an item with last set
`default_nettype none
`include "surface_patch_neighbor_update_unit_macros.svh"
module spnu_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  spnu_pkg::work_t  q_item,
  output logic [spnu_pkg::WADDR_W-1:0] w_raddr,
  input  wire logic [31:0] w_rdata,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_index,
  output logic [31:0]      out_value,
  output logic [spnu_pkg::COORD_W-1:0] out_x,
  output logic [spnu_pkg::COORD_W-1:0] out_y,
  output logic             out_last
);
  typedef enum logic [1:0] {S_IDLE, S_MAC, S_EMIT} state_t;
  state_t state;
  spnu_pkg::work_t cur;
  logic [spnu_pkg::ACC_W-1:0] accs [spnu_pkg::PATCH_LEN];
  logic [3:0] ri, mi, ei;
  logic rd_v, pr_v;
  logic [3:0] pr_i;
  logic signed [63:0] prod;
  logic [63:0] rnd;
  logic [spnu_pkg::ACC_W-1:0] cur_acc;

  assign q_ready = state == S_IDLE;
  assign w_raddr = spnu_pkg::WADDR_W'(({7'd0, cur.dir} * 9'(spnu_pkg::PATCH_LEN)
                   + {5'd0, ri}) * 9'(spnu_pkg::PATCH_LEN) + {5'd0, cur.j});
  assign rnd = 64'(prod) + 64'd32768;
  assign cur_acc = accs[ei];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; rd_v <= 1'b0; pr_v <= 1'b0; out_valid <= 1'b0;
      for (int k = 0; k < spnu_pkg::PATCH_LEN; k++) accs[k] <= '0;
    end else begin
      // pipeline: address, ram read, multiply, accumulate
      rd_v <= 1'b0; pr_v <= rd_v;
      if (rd_v) begin
        prod <= $signed(w_rdata) * $signed(cur.a);
        pr_i <= mi;
      end
      if (pr_v) accs[pr_i] <= accs[pr_i] - rnd[16 +: spnu_pkg::ACC_W];
      unique case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_item; ri <= '0;
          state <= q_item.acc ? S_MAC : S_EMIT;
          ei <= '0;
        end
        S_MAC: begin
          if (ri < 4'(spnu_pkg::PATCH_LEN)) begin
            rd_v <= 1'b1; mi <= ri; ri <= ri + 4'd1;
          end else if (!rd_v && !pr_v) begin
            state <= cur.emit ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (ei == 4'(spnu_pkg::PATCH_LEN)) begin
              if (out_ready || !out_valid) begin
                out_valid <= 1'b0; state <= S_IDLE;
              end
            end else begin
              out_valid <= 1'b1;
              out_index <= ei;
              if (!cur_acc[47] && |cur_acc[46:31]) out_value <= 32'h7FFFFFFF;
              else if (cur_acc[47] && !(&cur_acc[46:31])) out_value <= 32'h80000000;
              else out_value <= cur_acc[31:0];
              out_x <= cur.px; out_y <= cur.py;
              out_last <= ei == 4'(spnu_pkg::PATCH_LEN - 1);
              accs[ei] <= '0;
              ei <= ei + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SPN_ASSERT_IMPL(a_no_emit_mac, clk, rst, state == S_MAC, !out_valid, "result during mac")
  `SPN_ASSERT_IMPL(a_last_idx, clk, rst, out_valid && out_last, out_index == 4'd9,
                   "last on wrong index")
  `SPN_ASSERT_IMPL(a_pipe_in_mac, clk, rst, rd_v, state == S_MAC, "read outside mac")
endmodule
`default_nettype wire

FILE: rtl/surface_patch_neighbor_update_unit.sv
// top level of the surface patch neighbor update unit
// usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets subst_mode (0)
//    and break_threshold (1); always ready, write only while idle
//  - input items (in_valid/in_ready) load weights, the center patch and neighbor
//    coefficients; loads complete in the front end
//  - a weight load is held off while neighbor items are queued, in the mac steps or emitting results
//  - each in-range neighbor coefficient is taken from the queue, then the back
//    end makes ten reads of the weight ram through one shared multiplier and
//    waits for the pipeline to drain
//  - a neighbor item with last set then yields ten result items, index 0 first,
//    one per cycle while out_ready is high; accumulators clear as sent
//  - a two-entry queue lets the front take non-weight loads while the back works
//  - reset clears accumulators, flags, label and registers; weights and center
//    patch are undefined until written
//  - when out_ready is low the result holds and the back end waits; the
//    queue then fills and in_ready drops
`default_nettype none
module surface_patch_neighbor_update_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [1:0]  direction,
  input  wire logic [3:0]  weight_row,
  input  wire logic [3:0]  coef_index,
  input  wire logic [31:0] value,
  input  wire logic [7:0]  label,
  input  wire logic [spnu_pkg::COORD_W-1:0] pixel_x,
  input  wire logic [spnu_pkg::COORD_W-1:0] pixel_y,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_index,
  output logic [31:0]      out_value,
  output logic [spnu_pkg::COORD_W-1:0] out_x,
  output logic [spnu_pkg::COORD_W-1:0] out_y,
  output logic             out_last
);
  logic [1:0] subst_mode;
  logic [30:0] break_threshold;
  logic w_we, q_valid, q_ready;
  logic [spnu_pkg::WADDR_W-1:0] w_waddr, w_raddr;
  logic [31:0] w_wdata, w_rdata;
  spnu_pkg::work_t q_item;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      subst_mode <= '0; break_threshold <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == spnu_pkg::CFG_MODE) subst_mode <= cfg_data[1:0];
      else break_threshold <= cfg_data[30:0];
    end
  end

  spnu_front u_front (
    .clk, .rst, .subst_mode, .break_threshold, .in_valid, .in_ready, .opcode,
    .direction, .weight_row, .coef_index, .value, .label,
    .pixel_x, .pixel_y, .last,
    .w_we, .w_waddr, .w_wdata, .q_valid, .q_ready, .q_item
  );

  spnu_ram #(.WIDTH(32), .DEPTH(400)) u_wram (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata)
  );

  spnu_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .w_raddr, .w_rdata,
    .out_valid, .out_ready, .out_index, .out_value, .out_x, .out_y, .out_last
  );
endmodule
`default_nettype wire

FILE: bench/tb_surface_patch_neighbor_update_unit.sv
// testbench of the surface patch neighbor update unit with its own update predictor
`default_nettype none
module tb_surface_patch_neighbor_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  // weight columns loaded; in-range neighbor coefficients use only these indices
  localparam int WEIGHT_COLS = 3;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] val;
    logic [9:0]  x;
    logic [9:0]  y;
    logic        lst;
  } coef_out_t;

  class patch_update_board;
    logic signed [31:0] weights [spnu_pkg::NUM_DIRS*spnu_pkg::PATCH_LEN*spnu_pkg::PATCH_LEN];
    logic signed [31:0] center [spnu_pkg::PATCH_LEN];
    logic [47:0] acc [spnu_pkg::PATCH_LEN];
    logic [7:0] center_lab;
    logic [3:0] replaced;
    logic [1:0] mode;
    logic [30:0] thresh;
    coef_out_t pending_coefs[$];
    int errors;
    int checked;

    function void clear();
      foreach (acc[i]) acc[i] = '0;
      foreach (weights[i]) weights[i] = '0;
      foreach (center[i]) center[i] = '0;
      center_lab = '0;
      replaced = '0;
      mode = '0;
      thresh = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic ridx, logic [31:0] data);
      if (ridx == spnu_pkg::CFG_MODE) mode = data[1:0];
      else thresh = data[30:0];
    endfunction

    function void note_item(spnu_pkg::opcode_t op, logic [1:0] dir, logic [3:0] row,
                            logic [3:0] j, logic [31:0] v, logic [7:0] lab,
                            logic [9:0] px, logic [9:0] py, logic lst);
      longint diff, prod, t, s;
      logic signed [31:0] a;
      logic rep;
      coef_out_t o;
      if (op == spnu_pkg::OP_WEIGHT) begin
        if (row < spnu_pkg::PATCH_LEN && j < spnu_pkg::PATCH_LEN)
          weights[(dir*spnu_pkg::PATCH_LEN + row)*spnu_pkg::PATCH_LEN + j] = v;
        return;
      end
      if (op == spnu_pkg::OP_CENTER) begin
        if (j < spnu_pkg::PATCH_LEN) begin
          center[j] = v;
          if (j == 0) center_lab = lab;
        end
        return;
      end
      if (op != spnu_pkg::OP_NEIGHBOR) return;
      if (j < spnu_pkg::PATCH_LEN) begin
        if (j == 0) begin
          rep = 1'b0;
          if (mode == spnu_pkg::MODE_THRESH) begin
            diff = longint'(center[0]) - longint'($signed(v));
            if (diff < 0) diff = -diff;
            rep = diff > longint'(thresh);
          end else if (mode == spnu_pkg::MODE_MASK) begin
            rep = lab != center_lab;
          end
          replaced[dir] = rep;
        end
        a = replaced[dir] ? center[j] : $signed(v);
        for (int i = 0; i < spnu_pkg::PATCH_LEN; i++) begin
          prod = longint'(weights[(dir*spnu_pkg::PATCH_LEN + i)*spnu_pkg::PATCH_LEN + j])
                 * longint'(a);
          t = (prod + 64'sd32768) >>> 16;
          acc[i] = acc[i] - t[47:0];
        end
      end
      if (!lst) return;
      for (int i = 0; i < spnu_pkg::PATCH_LEN; i++) begin
        s = {{16{acc[i][47]}}, acc[i]};
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        o.idx = i[3:0];
        o.val = s[31:0];
        o.x = px;
        o.y = py;
        o.lst = (i == spnu_pkg::PATCH_LEN-1);
        pending_coefs.push_back(o);
        acc[i] = '0;
      end
    endfunction

    function void check_coef(coef_out_t got);
      coef_out_t e;
      checked++;
      if (pending_coefs.size() == 0) begin
        $display("%0t: unexpected result index %0d value %h", $time, got.idx, got.val);
        errors++;
        return;
      end
      e = pending_coefs.pop_front();
      if (got.idx !== e.idx) begin
        $display("%0t: out_index expected %0d actual %0d", $time, e.idx, got.idx); errors++;
      end
      if (got.val !== e.val) begin
        $display("%0t: out_value expected %h actual %h", $time, e.val, got.val); errors++;
      end
      if (got.x !== e.x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.y, got.y); errors++;
      end
      if (got.lst !== e.lst) begin
        $display("%0t: out_last expected %0b actual %0b", $time, e.lst, got.lst); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] opcode, direction;
  logic [3:0] weight_row, coef_index;
  logic [31:0] value;
  logic [7:0] label;
  logic [9:0] pixel_x, pixel_y;
  logic last;
  logic out_valid, out_ready;
  logic [3:0] out_index;
  logic [31:0] out_value;
  logic [9:0] out_x, out_y;
  logic out_last;

  patch_update_board board;
  int cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int pixels_done = 0;
  logic [9:0] cur_x, cur_y;
  logic [7:0] cur_lab;

  surface_patch_neighbor_update_unit i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .opcode, .direction, .weight_row, .coef_index,
    .value, .label, .pixel_x, .pixel_y, .last,
    .out_valid, .out_ready, .out_index, .out_value, .out_x, .out_y, .out_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check, then stall in phases of no stall, light and heavy stall
  always @(posedge clk) begin
    coef_out_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.idx = out_index;
        got.val = out_value;
        got.x = out_x;
        got.y = out_y;
        got.lst = out_last;
        board.check_coef(got);
      end
      case ((cycles / 300) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  task automatic send_item(spnu_pkg::opcode_t op, logic [1:0] dir, logic [3:0] row,
                           logic [3:0] j, logic [31:0] v, logic [7:0] lab, logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= op;
    direction <= dir;
    weight_row <= row;
    coef_index <= j;
    value <= v;
    label <= lab;
    pixel_x <= cur_x;
    pixel_y <= cur_y;
    last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(op, dir, row, j, v, lab, cur_x, cur_y, lst);
    items_sent++;
  endtask

  task automatic write_reg(logic ridx, logic [31:0] data);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(ridx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.pending_coefs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'h0;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  // one pixel: full center patch, then neighbor coefficients with last at the end
  task automatic send_pixel(bit noisy);
    logic [31:0] h;
    logic [31:0] nv;
    int ndirs;
    logic [1:0] dir;
    logic [3:0] lj;
    cur_x = 10'($urandom_range(0, 1023));
    cur_y = 10'($urandom_range(0, 1023));
    cur_lab = 8'($urandom_range(0, 255));
    h = rand_value();
    send_item(spnu_pkg::OP_CENTER, 2'($urandom), 4'($urandom), 4'd0, h, cur_lab,
              1'($urandom));
    for (int j = 1; j < spnu_pkg::PATCH_LEN; j++)
      send_item(spnu_pkg::OP_CENTER, 2'($urandom), 4'($urandom), j[3:0], rand_value(),
                8'($urandom), 1'($urandom));
    ndirs = $urandom_range(1, 4);
    for (int d = 0; d < ndirs; d++) begin
      dir = (ndirs == 4) ? d[1:0] : 2'($urandom_range(0, 3));
      nv = ($urandom_range(0, 1) == 1) ? h + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000
                                       : rand_value();
      send_item(spnu_pkg::OP_NEIGHBOR, dir, 4'($urandom), 4'd0, nv,
                ($urandom_range(0, 1) == 1) ? cur_lab : 8'($urandom), 1'b0);
      for (int j = 1; j < WEIGHT_COLS; j++)
        if ($urandom_range(0, 3) != 0)
          send_item(spnu_pkg::OP_NEIGHBOR, dir, 4'($urandom), j[3:0], rand_value(),
                    8'($urandom), 1'b0);
      if (noisy && $urandom_range(0, 2) == 0)
        send_item(spnu_pkg::opcode_t'($urandom_range(0, 3)), 2'($urandom),
                  4'($urandom_range(10, 15)), 4'($urandom_range(10, 15)), $urandom,
                  8'($urandom), 1'b0);
    end
    lj = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, WEIGHT_COLS - 1))
                                     : 4'($urandom_range(10, 15));
    send_item(spnu_pkg::OP_NEIGHBOR, 2'($urandom), 4'($urandom), lj, rand_value(),
              8'($urandom), 1'b1);
    pixels_done++;
  endtask

  initial begin
    board = new();
    board.clear();
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= spnu_pkg::OP_NONE;
    direction <= '0;
    weight_row <= '0;
    coef_index <= '0;
    value <= '0;
    label <= '0;
    pixel_x <= '0;
    pixel_y <= '0;
    last <= 1'b0;
    cur_x = '0;
    cur_y = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every weight entry that a neighbor item reads is written first
    for (int d = 0; d < spnu_pkg::NUM_DIRS; d++)
      for (int r = 0; r < spnu_pkg::PATCH_LEN; r++)
        for (int c = 0; c < WEIGHT_COLS; c++)
          send_item(spnu_pkg::OP_WEIGHT, d[1:0], r[3:0], c[3:0],
                    (d == 3 && r == 0) ? 32'h7fff_ffff : rand_value(), 8'($urandom),
                    1'($urandom));

    // directed: out of range loads, unused opcode, saturation in both directions
    send_item(spnu_pkg::OP_WEIGHT, 2'd1, 4'd15, 4'd3, $urandom, 8'hff, 1'b1);
    send_item(spnu_pkg::OP_WEIGHT, 2'd2, 4'd2, 4'd10, $urandom, 8'h00, 1'b0);
    send_item(spnu_pkg::OP_NONE, 2'd3, 4'd9, 4'd9, 32'hffff_ffff, 8'hff, 1'b1);
    cur_x = 10'h3ff;
    cur_y = 10'h3ff;
    for (int j = 0; j < spnu_pkg::PATCH_LEN; j++)
      send_item(spnu_pkg::OP_CENTER, 2'd0, 4'd0, j[3:0], 32'h7fff_ffff, 8'hff, 1'b0);
    send_item(spnu_pkg::OP_CENTER, 2'd0, 4'd0, 4'd12, 32'h1234_5678, 8'h55, 1'b1);
    send_item(spnu_pkg::OP_NEIGHBOR, 2'd3, 4'd0, 4'd0, 32'h8000_0000, 8'h00, 1'b0);
    send_item(spnu_pkg::OP_NEIGHBOR, 2'd3, 4'd0, 4'd0, 32'h7fff_ffff, 8'h00, 1'b1);
    cur_x = '0;
    cur_y = '0;
    send_item(spnu_pkg::OP_NEIGHBOR, 2'd3, 4'd0, 4'd0, 32'h8000_0000, 8'h00, 1'b0);
    send_item(spnu_pkg::OP_NEIGHBOR, 2'd3, 4'd0, 4'd0, 32'h8000_0000, 8'h00, 1'b1);
    send_item(spnu_pkg::OP_NEIGHBOR, 2'd1, 4'd0, 4'd15, 32'h0, 8'h00, 1'b1);

    // phases over the register settings, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      wait_quiet();
      write_reg(spnu_pkg::CFG_MODE, (ph < 4) ? 32'(ph) : 32'($urandom_range(0, 3)));
      case (ph)
        1: write_reg(spnu_pkg::CFG_THRESH, 32'h0);
        5: write_reg(spnu_pkg::CFG_THRESH, 32'hffff_ffff);
        default: write_reg(spnu_pkg::CFG_THRESH,
                           (ph % 2) ? $urandom_range(0, 32'h0002_0000) : $urandom);
      endcase
      send_pixel(ph > 1);
    end

    wait_quiet();
    $display("sent %0d items over %0d pixels in 8 register phases", items_sent, pixels_done);
    $display("checked %0d results, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0 && board.pending_coefs.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
